>>> rtl/core/scl2x_pkg.sv
`default_nettype none

package scl2x_pkg;

   // item field widths
   localparam int PIX_W        = 32;
   localparam int COL_OUT_W    = 10;
   localparam int ROW_OUT_W    = 12;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;

   // stream payload sizes, packed and rounded up to whole bytes
   localparam int REQ_DATA_W    = 32;
   localparam int RSP_FIELDS_W  = 4 * PIX_W + COL_OUT_W + ROW_OUT_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   typedef logic [PIX_W-1:0] pixel_type;

   // per-item position flags, from the sequencer to the output stage
   typedef struct packed {
      logic has_prev;   // row above exists, a block of it is due
      logic last_row;   // item is in the last row of the frame
      logic x_gt0;
      logic x_gt1;
      logic x_last;     // item is in the last column
      logic y_gt1;      // previous row has a row above it
      logic y_odd;
   } item_flags_type;

   typedef struct packed {
      pixel_type br;
      pixel_type bl;
      pixel_type tr;
      pixel_type tl;
   } block_type;

   // scale2x corner rule
   function automatic block_type scale2x_corners(input pixel_type c, input pixel_type u,
                                                 input pixel_type l, input pixel_type r,
                                                 input pixel_type d);
      block_type blk;
      blk.tl = c;
      blk.tr = c;
      blk.bl = c;
      blk.br = c;
      if (u != d && l != r) begin
         blk.tl = (l == u) ? l : c;
         blk.tr = (u == r) ? r : c;
         blk.bl = (l == d) ? l : c;
         blk.br = (d == r) ? r : c;
      end
      return blk;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/scl2x_ram.sv
`default_nettype none

module scl2x_ram
   import scl2x_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // one write port, two registered read ports, old data on a same-address read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

>>> rtl/core/scl2x_seq.sv
`default_nettype none

module scl2x_seq
   import scl2x_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_wdata,
   input  wire logic                          load_ok,
   input  wire logic                          stage_idle,
   output logic                               accept,
   output logic      [$clog2(MAX_WIDTH)-1:0]  item_x,
   output logic      [$clog2(MAX_HEIGHT)-1:0] item_y,
   output item_flags_type                     item_flags,
   output logic                               wr_en_even,
   output logic                               wr_en_odd,
   output logic      [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   output logic                               rd_en,
   output logic      [$clog2(MAX_WIDTH)-1:0]  rd_addr_a,
   output logic      [$clog2(MAX_WIDTH)-1:0]  rd_addr_b
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   // clamp a width register value to 1..MAX_WIDTH, kept as last column
   function automatic logic [CW-1:0] width_last(input logic [CFG_WIDTH_W-1:0] v);
      logic [CW-1:0] res;
      if (v == '0) begin
         res = '0;
      end else if (int'(v) > MAX_WIDTH) begin
         res = CW'(MAX_WIDTH - 1);
      end else begin
         res = CW'(v - 1'b1);
      end
      return res;
   endfunction

   function automatic logic [RW-1:0] height_last(input logic [CFG_HEIGHT_W-1:0] v);
      logic [RW-1:0] res;
      if (v == '0) begin
         res = '0;
      end else if (int'(v) > MAX_HEIGHT) begin
         res = RW'(MAX_HEIGHT - 1);
      end else begin
         res = RW'(v - 1'b1);
      end
      return res;
   endfunction

   logic [CW-1:0] wlast_ff, wlast_in;
   logic [RW-1:0] hlast_ff, hlast_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          win_ok_ff, win_ok_in;

   logic [CW-1:0] x;
   logic [RW-1:0] y;
   logic          csr_write;
   logic          fix_need;
   logic          fix_issue;

   // position of this item, counts beyond a shrunk frame land on the last column or row
   assign x = (col_ff > wlast_ff) ? wlast_ff : col_ff;
   assign y = (row_ff > hlast_ff) ? hlast_ff : row_ff;

   // left neighbor register is stale after a size change, refetch it before the item
   assign fix_need  = !win_ok_ff && (x != '0) && (y != '0);
   assign fix_issue = fix_need && stage_idle;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_tready = !reset && load_ok && !fix_need;
   assign accept     = req_tvalid && req_tready;

   // next state
   always_comb begin
      wlast_in  = wlast_ff;
      hlast_in  = hlast_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      win_ok_in = win_ok_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  wlast_in = width_last(csr_wdata[CFG_WIDTH_W-1:0]);
            REG_IMAGE_HEIGHT: hlast_in = height_last(csr_wdata[CFG_HEIGHT_W-1:0]);
            default: ;
         endcase
         win_ok_in = 1'b0;
      end else if (accept || fix_issue) begin
         win_ok_in = 1'b1;
      end
      if (accept) begin
         if (x == wlast_ff) begin
            col_in = '0;
            row_in = (y == hlast_ff) ? '0 : y + 1'b1;
         end else begin
            col_in = x + 1'b1;
            row_in = y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff  <= width_last(CFG_WIDTH_W'(256));
         hlast_ff  <= height_last(CFG_HEIGHT_W'(224));
         col_ff    <= '0;
         row_ff    <= '0;
         win_ok_ff <= 1'b0;
      end else begin
         wlast_ff  <= wlast_in;
         hlast_ff  <= hlast_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         win_ok_ff <= win_ok_in;
      end
   end

   // item position to the output stage
   assign item_x              = x;
   assign item_y              = y;
   assign item_flags.has_prev = (y != '0);
   assign item_flags.last_row = (y == hlast_ff);
   assign item_flags.x_gt0    = (x != '0);
   assign item_flags.x_gt1    = (x > CW'(1));
   assign item_flags.x_last   = (x == wlast_ff);
   assign item_flags.y_gt1    = (y > RW'(1));
   assign item_flags.y_odd    = y[0];

   // line store: write this row's store, read both stores at x (x-1 on refetch) and x+1
   assign wr_en_even = accept && !y[0];
   assign wr_en_odd  = accept && y[0];
   assign wr_addr    = x;
   assign rd_en      = accept || fix_issue;
   assign rd_addr_a  = fix_issue ? x - 1'b1 : x;
   assign rd_addr_b  = x + 1'b1;

endmodule

`default_nettype wire

>>> rtl/core/scl2x_emit.sv
`default_nettype none

module scl2x_emit
   import scl2x_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]  item_x,
   input  wire logic [$clog2(MAX_HEIGHT)-1:0] item_y,
   input  wire item_flags_type                item_flags,
   input  wire pixel_type                     pixel,
   input  wire pixel_type                     ram_a_even,
   input  wire pixel_type                     ram_b_even,
   input  wire pixel_type                     ram_a_odd,
   input  wire pixel_type                     ram_b_odd,
   output logic                               load_ok,
   output logic                               stage_idle,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [RSP_DATA_W-1:0]         rsp_tdata,
   output logic                               rsp_tlast
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   // which block of the item is due
   localparam logic [1:0] RES_PREV_ROW    = 2'd0;
   localparam logic [1:0] RES_LAST_LEFT   = 2'd1;
   localparam logic [1:0] RES_LAST_CORNER = 2'd2;

   logic [2:0]      mask_ff, mask_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic            rsp_last_ff, rsp_last_in;
   pixel_type       prior_ff, prior_in;
   pixel_type       second_ff, second_in;

   item_flags_type  flags_ff;
   logic [CW-1:0]   x_ff;
   logic [RW-1:0]   y_ff;
   pixel_type       p_ff;
   pixel_type       s_prior_ff;
   pixel_type       s_second_ff;
   pixel_type       win_ff;

   logic            busy;
   logic            out_free;
   logic            single;
   logic            emit;
   logic [1:0]      kind;
   pixel_type       cur_a, cur_b, up_a;
   pixel_type       nc, nu, nl, nr, nd;
   logic [CW-1:0]   col;
   logic [RW-1:0]   row;
   logic            done;
   block_type       blk;

   // stage occupancy: one pending bit per block of the held item
   assign busy       = (mask_ff != 3'd0);
   assign stage_idle = !busy;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign single     = ((mask_ff & (mask_ff - 3'd1)) == 3'd0);
   assign load_ok    = !busy || (out_free && single);
   assign emit       = busy && out_free;

   always_comb begin
      if (mask_ff[0]) begin
         kind = RES_PREV_ROW;
      end else if (mask_ff[1]) begin
         kind = RES_LAST_LEFT;
      end else begin
         kind = RES_LAST_CORNER;
      end
   end

   // previous row lives in the store of opposite parity
   assign cur_a = flags_ff.y_odd ? ram_a_even : ram_a_odd;
   assign cur_b = flags_ff.y_odd ? ram_b_even : ram_b_odd;
   assign up_a  = flags_ff.y_odd ? ram_a_odd  : ram_a_even;

   // neighbor selection per block, frame edges fall back to the center
   always_comb begin
      nc   = p_ff;
      nu   = p_ff;
      nl   = p_ff;
      nr   = p_ff;
      nd   = p_ff;
      col  = x_ff;
      row  = y_ff;
      done = 1'b0;
      unique case (kind)
         RES_PREV_ROW: begin
            nc  = cur_a;
            nu  = flags_ff.y_gt1 ? up_a : cur_a;
            nl  = flags_ff.x_gt0 ? win_ff : cur_a;
            nr  = flags_ff.x_last ? cur_a : cur_b;
            nd  = p_ff;
            row = y_ff - 1'b1;
         end
         RES_LAST_LEFT: begin
            nc  = s_prior_ff;
            nu  = flags_ff.has_prev ? win_ff : s_prior_ff;
            nl  = flags_ff.x_gt1 ? s_second_ff : s_prior_ff;
            nr  = p_ff;
            nd  = s_prior_ff;
            col = x_ff - 1'b1;
         end
         RES_LAST_CORNER: begin
            nu   = flags_ff.has_prev ? cur_a : p_ff;
            nl   = flags_ff.x_gt0 ? s_prior_ff : p_ff;
            done = 1'b1;
         end
         default: ;
      endcase
   end

   assign blk = scale2x_corners(nc, nu, nl, nr, nd);

   // next state of control and output register
   always_comb begin
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      prior_in     = prior_ff;
      second_in    = second_ff;
      if (emit) begin
         mask_in      = mask_ff & (mask_ff - 3'd1);
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({ROW_OUT_W'(row), COL_OUT_W'(col), blk});
         rsp_last_in  = done;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         mask_in   = {item_flags.last_row && item_flags.x_last,
                      item_flags.last_row && item_flags.x_gt0,
                      item_flags.has_prev};
         prior_in  = pixel;
         second_in = prior_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
         prior_ff     <= '0;
         second_ff    <= '0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
         prior_ff     <= prior_in;
         second_ff    <= second_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // held item; the left neighbor is what the store read for the item before
   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff    <= item_flags;
         x_ff        <= item_x;
         y_ff        <= item_y;
         p_ff        <= pixel;
         s_prior_ff  <= prior_ff;
         s_second_ff <= second_ff;
         win_ff      <= item_flags.y_odd ? ram_a_even : ram_a_odd;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/core/scale2x_pixel_upscaler.sv
// Scale2x upscaler for a stream of 32-bit ARGB pixels in raster order.
// req channel: one source pixel per item in req_tdata.
// rsp channel: one 2x2 output block per source pixel, with its source column and
//   row; rsp_tlast marks the final block of the frame.
// csr channel: register 0 is the frame width, register 1 the frame height; write
//   only while no item is in flight. csr_ready is always high.
// Blocks of row r come out while row r+1 arrives; the last row follows its input
// with a one-pixel lag and its last pixel also flushes the final block.
// A block is formed from the held item and then registered in the output register.
// Throughput: one item per cycle while rsp is ready; in the last row an item past
//   column 0 gives two blocks when a row lies above, and the final pixel one more,
//   all through the single output register. An item that resumes a row past column 0
//   below row 0 after a register write waits while the left neighbor is refetched
//   from the line store.
// Two line stores (even and odd rows) are read at x and x+1 on every item, and the
// current row's store is written at x in the same cycle.
// Reset clears position counters and the output register; the line stores are not
// cleared and need no clearing pass. A stalled rsp holds its block and, once the
// single block stage is full, req_tready drops.
`default_nettype none

module scale2x_pixel_upscaler
   import scl2x_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // pixel_in[31:0]
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,
   // top_left[31:0], top_right[63:32], bottom_left[95:64], bottom_right[127:96],
   // block_col[137:128], block_row[149:138], zero pad[151:150]
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic      [RSP_DATA_W-1:0]   rsp_tdata,
   output logic                         rsp_tlast,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic           load_ok;
   logic           stage_idle;
   logic           accept;
   logic [CW-1:0]  item_x;
   logic [RW-1:0]  item_y;
   item_flags_type item_flags;
   logic           wr_en_even;
   logic           wr_en_odd;
   logic [CW-1:0]  wr_addr;
   logic           rd_en;
   logic [CW-1:0]  rd_addr_a;
   logic [CW-1:0]  rd_addr_b;
   pixel_type      ram_a_even, ram_b_even;
   pixel_type      ram_a_odd, ram_b_odd;

   // position counters, size registers and line store addressing
   scl2x_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .load_ok    (load_ok),
      .stage_idle (stage_idle),
      .accept     (accept),
      .item_x     (item_x),
      .item_y     (item_y),
      .item_flags (item_flags),
      .wr_en_even (wr_en_even),
      .wr_en_odd  (wr_en_odd),
      .wr_addr    (wr_addr),
      .rd_en      (rd_en),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b)
   );

   // even row line store
   scl2x_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_store_even (
      .clock     (clock),
      .wr_en     (wr_en_even),
      .wr_addr   (wr_addr),
      .wr_data   (req_tdata[PIX_W-1:0]),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (ram_a_even),
      .rd_data_b (ram_b_even)
   );

   // odd row line store
   scl2x_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_store_odd (
      .clock     (clock),
      .wr_en     (wr_en_odd),
      .wr_addr   (wr_addr),
      .wr_data   (req_tdata[PIX_W-1:0]),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (ram_a_odd),
      .rd_data_b (ram_b_odd)
   );

   // block stage, corner rule and output register
   scl2x_emit #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .item_x     (item_x),
      .item_y     (item_y),
      .item_flags (item_flags),
      .pixel      (req_tdata[PIX_W-1:0]),
      .ram_a_even (ram_a_even),
      .ram_b_even (ram_b_even),
      .ram_a_odd  (ram_a_odd),
      .ram_b_odd  (ram_b_odd),
      .load_ok    (load_ok),
      .stage_idle (stage_idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> rtl/core/scl2x_checker.sv
`default_nettype none

module scl2x_checker
   import scl2x_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast
);

   pixel_type tl, tr, bl, br;

   assign tl = rsp_tdata[PIX_W-1:0];
   assign tr = rsp_tdata[2*PIX_W-1:PIX_W];
   assign bl = rsp_tdata[3*PIX_W-1:2*PIX_W];
   assign br = rsp_tdata[4*PIX_W-1:3*PIX_W];

   // stalled block holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp block changed while stalled");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // bent corners all lie on one diagonal
   a_corner_pairs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (tr == bl) || (tl == br))
      else $error("corner rule violated");

   // final block sits at the bottom right corner, only top left can differ
   a_frame_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (tr == bl) && (bl == br))
      else $error("final block of frame malformed");

endmodule

bind scale2x_pixel_upscaler scl2x_checker u_scl2x_checker (.*);

`default_nettype wire

>>> tb/scale2x_block_checker.sv
module scale2x_block_checker
   import scl2x_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // pixel_in[31:0]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // top_left, top_right, bottom_left, bottom_right, block_col, block_row, zero pad
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    blocks_pending,
   output int                    blocks_checked
);

   localparam int REPORT_LIMIT = 10;
   localparam int COL_LSB      = 4 * PIX_W;
   localparam int ROW_LSB      = COL_LSB + COL_OUT_W;
   localparam int PAD_LSB      = ROW_LSB + ROW_OUT_W;

   typedef struct packed {
      pixel_type            tl;
      pixel_type            tr;
      pixel_type            bl;
      pixel_type            br;
      logic [COL_OUT_W-1:0] col;
      logic [ROW_OUT_W-1:0] row;
      logic                 done;
   } out_block_type;

   // predictor state: sizes, two row buffers, position and the last two pixels
   logic [CFG_WIDTH_W-1:0]  frame_width;
   logic [CFG_HEIGHT_W-1:0] frame_height;
   pixel_type               row_store [2][MAX_WIDTH];
   int unsigned             next_col;
   int unsigned             next_row;
   pixel_type               last_pix;
   pixel_type               last_pix2;
   out_block_type           expected_blocks [$];

   // expand one center pixel into its 2x2 block
   function automatic out_block_type upscale_block(input pixel_type c, u, l, r, d,
                                                   input int unsigned col, row,
                                                   input logic done);
      out_block_type blk;
      blk.tl = c;
      blk.tr = c;
      blk.bl = c;
      blk.br = c;
      // corners only bend toward a neighbor where both opposite pairs differ
      if (u != d && l != r) begin
         if (l == u) blk.tl = l;
         if (u == r) blk.tr = r;
         if (l == d) blk.bl = l;
         if (d == r) blk.br = r;
      end
      blk.col  = col[COL_OUT_W-1:0];
      blk.row  = row[ROW_OUT_W-1:0];
      blk.done = done;
      return blk;
   endfunction

   always @(posedge clock) begin : track
      out_block_type got;
      out_block_type want;
      pixel_type     pix;
      pixel_type     c;
      pixel_type     u;
      pixel_type     l;
      pixel_type     r;
      int unsigned   w;
      int unsigned   h;
      int unsigned   x;
      int unsigned   y;
      int unsigned   above;

      if (reset) begin
         frame_width  = CFG_WIDTH_W'(256);
         frame_height = CFG_HEIGHT_W'(224);
         next_col     = 0;
         next_row     = 0;
         last_pix     = '0;
         last_pix2    = '0;
         expected_blocks.delete();
         mismatch_count = 0;
         blocks_checked = 0;
      end else begin
         // compare each delivered block with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.tl   = rsp_tdata[0 +: PIX_W];
            got.tr   = rsp_tdata[PIX_W +: PIX_W];
            got.bl   = rsp_tdata[2 * PIX_W +: PIX_W];
            got.br   = rsp_tdata[3 * PIX_W +: PIX_W];
            got.col  = rsp_tdata[COL_LSB +: COL_OUT_W];
            got.row  = rsp_tdata[ROW_LSB +: ROW_OUT_W];
            got.done = rsp_tlast;
            if (expected_blocks.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected block col %0d row %0d", $time, got.col, got.row);
            end else begin
               want = expected_blocks.pop_front();
               blocks_checked++;
               if (got !== want || rsp_tdata[RSP_DATA_W-1:PAD_LSB] !== '0) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: expected col %0d row %0d last %0b tl %h tr %h bl %h br %h",
                              $time, want.col, want.row, want.done,
                              want.tl, want.tr, want.bl, want.br);
                     $display("%0t: actual   col %0d row %0d last %0b tl %h tr %h bl %h br %h pad %h",
                              $time, got.col, got.row, got.done, got.tl, got.tr, got.bl, got.br,
                              rsp_tdata[RSP_DATA_W-1:PAD_LSB]);
                  end
               end
            end
         end

         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_IMAGE_WIDTH:  frame_width  = csr_wdata[CFG_WIDTH_W-1:0];
               REG_IMAGE_HEIGHT: frame_height = csr_wdata[CFG_HEIGHT_W-1:0];
               default: ;
            endcase
         end

         // predict the blocks that an accepted pixel completes
         if (req_tvalid && req_tready) begin
            pix = req_tdata[PIX_W-1:0];
            w = (frame_width == 0) ? 1 : (frame_width > MAX_WIDTH) ? MAX_WIDTH : frame_width;
            h = (frame_height == 0) ? 1 :
                (frame_height > MAX_HEIGHT) ? MAX_HEIGHT : frame_height;
            // a position past a shrunken size sticks to the last column or row
            x = (next_col < w) ? next_col : w - 1;
            y = (next_row < h) ? next_row : h - 1;

            // this pixel is the down neighbor of the block above it
            if (y > 0) begin
               above = y - 1;
               c = row_store[above & 1][x];
               u = (above > 0) ? row_store[y & 1][x] : c;
               l = (x > 0) ? row_store[above & 1][x - 1] : c;
               r = (x + 1 < w) ? row_store[above & 1][x + 1] : c;
               expected_blocks.push_back(upscale_block(c, u, l, r, pix, x, above, 1'b0));
            end
            row_store[y & 1][x] = pix;

            // last row: no row below, emit with a one-pixel lag and flush at the end
            if (y == h - 1) begin
               if (x > 0) begin
                  c = last_pix;
                  l = (x > 1) ? last_pix2 : c;
                  u = (y > 0) ? row_store[(y + 1) & 1][x - 1] : c;
                  expected_blocks.push_back(upscale_block(c, u, l, pix, c, x - 1, y, 1'b0));
               end
               if (x == w - 1) begin
                  l = (x > 0) ? last_pix : pix;
                  u = (y > 0) ? row_store[(y + 1) & 1][x] : pix;
                  expected_blocks.push_back(upscale_block(pix, u, l, pix, pix, x, y, 1'b1));
               end
            end

            last_pix2 = last_pix;
            last_pix  = pix;
            if (x + 1 < w) begin
               next_col = x + 1;
               next_row = y;
            end else begin
               next_col = 0;
               next_row = (y + 1 < h) ? y + 1 : 0;
            end
         end
      end
      blocks_pending = expected_blocks.size();
   end

endmodule

>>> tb/scale2x_pixel_upscaler_test.sv
module scale2x_pixel_upscaler_test;
   import scl2x_pkg::*;

   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 4096;
   localparam int RANDOM_PIXELS = 420;
   localparam int DRAIN_LIMIT   = 50000;
   // register slots with no register behind them
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // pixel_in[31:0]
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // top_left, top_right, bottom_left, bottom_right, block_col, block_row, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatch_count;
   int blocks_pending;
   int blocks_checked;
   int frames_sent;
   int pixels_sent;
   bit req_idle_on;
   bit rsp_stall_on;

   scale2x_pixel_upscaler #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   scale2x_block_checker #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_block_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .blocks_pending (blocks_pending),
      .blocks_checked (blocks_checked)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // output back-pressure: mostly short stalls, now and then a long one
   initial begin : rsp_backpressure
      int stall_left;
      int roll;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            roll = $urandom_range(0, 99);
            if (!rsp_stall_on || roll < 70) begin
               rsp_tready <= 1'b1;
            end else if (roll < 95) begin
               rsp_tready <= 1'b0;
               stall_left = $urandom_range(0, 2);
            end else begin
               rsp_tready <= 1'b0;
               stall_left = $urandom_range(8, 30);
            end
         end
      end
   end

   // run limit
   initial begin
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // one pixel item, with an optional idle gap ahead of it
   task automatic send_pixel(input pixel_type pix);
      int gap;
      int roll;
      gap = 0;
      if (req_idle_on) begin
         roll = $urandom_range(0, 99);
         if (roll >= 90) gap = $urandom_range(6, 24);
         else if (roll >= 60) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom();
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      pixels_sent++;
   endtask

   // stop input and let the block drain before touching registers
   task automatic settle();
      req_tvalid <= 1'b0;
      while (blocks_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input int cols, input int rows);
      settle();
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(cols));
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(rows));
   endtask

   // a frame's worth of pixels, mostly from a small palette so corners match
   task automatic send_random_pixels(input int count);
      pixel_type palette [4];
      int        mode;
      mode = $urandom_range(0, 9);
      foreach (palette[i]) palette[i] = $urandom();
      // colors one bit apart
      if (mode < 2) begin
         for (int i = 1; i < 4; i++) palette[i] = palette[0] ^ (32'h1 << $urandom_range(0, 31));
      end
      repeat (count) begin
         if (mode == 9) send_pixel($urandom());
         else send_pixel(palette[$urandom_range(0, (mode >= 2 && mode < 5) ? 1 : 3)]);
      end
   endtask

   initial begin : stimulus
      pixel_type shape [9];
      int        cols;
      int        rows;
      int        random_sent;
      int        waited;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= REG_IMAGE_WIDTH;
      csr_wdata   <= '0;
      req_idle_on  = 1'b1;
      rsp_stall_on = 1'b1;
      frames_sent  = 0;
      pixels_sent  = 0;
      random_sent  = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset sizes: the first row of the default frame gives no blocks
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_0000);
      // shrink mid-frame to a one-row, four-column frame and finish it
      settle();
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(1));
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(4));
      send_pixel(32'hA5A5_5A5A);
      frames_sent++;

      // zero sizes act as a single pixel frame
      configure(0, 0);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_0000);
      frames_sent += 2;

      // writes to unused slots must leave the sizes alone
      configure(3, 3);
      write_reg(REG_SPARE_LO, CSR_DATA_W'($urandom()));
      write_reg(REG_SPARE_HI, '1);

      // 3x3 frame whose center bends two corners
      shape = '{32'hFF00_00FF, 32'hFF00_00FF, 32'h00FF_FF00,
                32'hFF00_00FF, 32'h8080_8080, 32'h00FF_FF00,
                32'h00FF_FF00, 32'h00FF_FF00, 32'h00FF_FF00};
      foreach (shape[i]) send_pixel(shape[i]);
      frames_sent++;

      // oversize height, then cut the frame short below the current row
      configure(2, 8191);
      repeat (4) send_pixel($urandom());
      settle();
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(2));
      repeat (2) send_pixel($urandom());
      frames_sent++;

      // oversize width, then narrow it below the current column
      configure(2047, 1);
      repeat (3) send_pixel($urandom());
      settle();
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(2));
      send_pixel($urandom());
      frames_sent++;

      // random frames, mostly small
      while (random_sent < RANDOM_PIXELS) begin
         if ($urandom_range(0, 9) < 8) begin
            cols = $urandom_range(1, 10);
            rows = $urandom_range(1, 6);
         end else begin
            cols = $urandom_range(11, 40);
            rows = $urandom_range(1, 4);
         end
         if ($urandom_range(0, 19) == 0) cols = 0;
         if ($urandom_range(0, 19) == 0) rows = 0;
         req_idle_on  = ($urandom_range(0, 3) != 0);
         rsp_stall_on = ($urandom_range(0, 3) != 0);
         configure(cols, rows);
         send_random_pixels((cols == 0 ? 1 : cols) * (rows == 0 ? 1 : rows));
         random_sent += (cols == 0 ? 1 : cols) * (rows == 0 ? 1 : rows);
         frames_sent++;
      end

      // drain
      req_tvalid <= 1'b0;
      waited = 0;
      while (blocks_pending != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (10) @(negedge clock);

      if (blocks_pending != 0) $display("%0d predicted blocks never arrived", blocks_pending);
      $display("%0d frames, %0d source pixels sent, %0d output blocks checked",
               frames_sent, pixels_sent, blocks_checked);
      $display("frames from 1x1 to 40 columns, zero and oversize sizes, mid-frame shrinks");
      if (mismatch_count == 0 && blocks_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
